// ----- sv/pgs_pkg.sv -----
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared widths, codes, request structs and the byte address function of the
// packed genotype store.
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int MAX_INDIVIDUALS = 256;
    localparam int MAX_SNPS        = 1024;
    localparam int STORE_DEPTH     = MAX_INDIVIDUALS * ((MAX_SNPS + 3) / 4);
    localparam int GS_AW           = $clog2(STORE_DEPTH);
    localparam int CT_AW           = $clog2(MAX_SNPS);

    localparam int IND_CNT_W = 9;
    localparam int CNT_W     = 11;
    localparam int ROW_W     = 8;
    localparam int SNP_W     = 10;
    localparam int GENO_W    = 2;
    localparam int TOTAL_W   = 10;
    localparam int ERR_W     = 2;
    localparam int CFG_AW    = 2;

    // Item kinds
    localparam logic [1:0] KIND_READ      = 2'd0;
    localparam logic [1:0] KIND_WRITE     = 2'd1;
    localparam logic [1:0] KIND_COUNT     = 2'd2;
    localparam logic [1:0] KIND_READ_CNT  = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_IND = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SNP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_IND_CNT    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_STRIDE_CNT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_VALID_CNT  = 2'd2;

    typedef struct packed {
        logic             en;
        logic [GS_AW-1:0] addr;
    } t_geno_rd;

    typedef struct packed {
        logic               en;
        logic [CT_AW-1:0]   addr;
        logic [TOTAL_W-1:0] data;
    } t_tab_wr;

    // Byte address of a genotype: row * ceil(stride / 4) + snp / 4, wrapped
    // to the store depth.
    function automatic logic [GS_AW-1:0] geno_addr(
        input logic [IND_CNT_W-1:0] row,
        input logic [CNT_W-1:0]     stride,
        input logic [SNP_W-1:0]     snp
    );
        logic [CNT_W:0]                 stride_up;
        logic [CNT_W-2:0]               row_bytes;
        logic [IND_CNT_W+CNT_W-2:0]     prod;
        logic [IND_CNT_W+CNT_W-2:0]     sum;
        stride_up = {1'b0, stride} + (CNT_W+1)'(3);
        row_bytes = stride_up[CNT_W:2];
        prod      = (IND_CNT_W+CNT_W-1)'(row) * (IND_CNT_W+CNT_W-1)'(row_bytes);
        sum       = prod + (IND_CNT_W+CNT_W-1)'(snp[SNP_W-1:2]);
        return sum[GS_AW-1:0];
    endfunction

    // Allele count of one genotype code.
    function automatic logic [1:0] allele_of(input logic [GENO_W-1:0] g);
        return {1'b0, g[1]} + {1'b0, g[0]};
    endfunction

endpackage

// ----- sv/pgs_ram.sv -----
// ----------------------------------------------------------------------------
// pgs_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module pgs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/pgs_count.sv -----
// ----------------------------------------------------------------------------
// pgs_count
// Count pass sequencer: walks SNP by SNP over all rows, reads each byte from
// the genotype store and accumulates allele counts into the count table.
// ----------------------------------------------------------------------------
module pgs_count (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pgs_pkg::IND_CNT_W-1:0]   i_ind_cnt,
    input  logic [pgs_pkg::CNT_W-1:0]       i_stride_cnt,
    input  logic [pgs_pkg::CNT_W-1:0]       i_valid_cnt,
    input  logic [7:0]                      i_geno_rdata,
    output pgs_pkg::t_geno_rd               o_geno_rd,
    output pgs_pkg::t_tab_wr                o_tab_wr,
    output logic                            o_busy
);
    import pgs_pkg::*;

    logic                  r_run;
    logic [SNP_W-1:0]      r_snp;
    logic [IND_CNT_W-1:0]  r_row;
    logic                  r_p_valid;
    logic                  r_p_first;
    logic                  r_p_last;
    logic [SNP_W-1:0]      r_p_snp;
    logic [TOTAL_W-1:0]    r_acc;

    logic [CNT_W-1:0]      limit;
    logic [CNT_W-1:0]      limit_m1;
    logic [IND_CNT_W-1:0]  last_row;
    logic                  row_last;
    logic                  snp_last;
    logic [GENO_W-1:0]     g;
    logic [1:0]            contrib;
    logic [TOTAL_W-1:0]    acc_sum;

    assign limit    = (i_valid_cnt > CNT_W'(MAX_SNPS)) ? CNT_W'(MAX_SNPS) : i_valid_cnt;
    assign limit_m1 = limit - CNT_W'(1);
    // With no rows each SNP still takes one slot that contributes nothing.
    assign last_row = (i_ind_cnt == '0) ? '0 : i_ind_cnt - IND_CNT_W'(1);
    assign row_last = (r_row == last_row);
    assign snp_last = ({1'b0, r_snp} == limit_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= r_run;
            if (i_start && !r_run) begin
                r_run <= (limit != '0);
            end else if (r_run && row_last && snp_last) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_run) begin
            r_snp <= '0;
            r_row <= '0;
        end else if (r_run) begin
            if (row_last) begin
                r_row <= '0;
                r_snp <= r_snp + SNP_W'(1);
            end else begin
                r_row <= r_row + IND_CNT_W'(1);
            end
        end
        r_p_first <= (r_row == '0);
        r_p_last  <= row_last;
        r_p_snp   <= r_snp;
        if (r_p_valid) begin
            r_acc <= acc_sum;
        end
    end

    // The byte comes back from the registered store read; the tags are registered alongside it.
    assign g       = i_geno_rdata[{r_p_snp[1:0], 1'b0} +: GENO_W];
    assign contrib = (i_ind_cnt != '0) ? allele_of(g) : 2'd0;
    assign acc_sum = (r_p_first ? '0 : r_acc) + TOTAL_W'(contrib);

    assign o_geno_rd.en   = r_run;
    assign o_geno_rd.addr = geno_addr(r_row, i_stride_cnt, r_snp);
    assign o_tab_wr.en    = r_p_valid && r_p_last;
    assign o_tab_wr.addr  = r_p_snp[CT_AW-1:0];
    assign o_tab_wr.data  = acc_sum;
    assign o_busy         = r_run || r_p_valid;

endmodule

// ----- sv/packed_genotype_store.sv -----
// ----------------------------------------------------------------------------
// packed_genotype_store
// Packed 2-bit genotype matrix with per-SNP allele count table.
// ----------------------------------------------------------------------------
// Genotype read, genotype write and count read: the byte or count is read as the
//   request is accepted; the access state registers the result (a write merges
//   the byte back) once the output is free. Only then is a new request taken.
// Count pass: min(snp_valid_count, 1024) * max(individual_count, 1) store
//   reads, one store read per cycle.
// On reset a clearing pass over all 65536 store bytes zeroes both memories; no request is
//   accepted until it ends, configuration writes are taken throughout.
module packed_genotype_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [pgs_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [pgs_pkg::CNT_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: individual[7:0], snp_index[17:8], genotype[19:18], zero[23:20]
    input  logic [23:0]                   i_s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]                    i_s_axis_tuser,
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: genotype_out[1:0], allele_total[11:2], error_code[13:12], zero[15:14]
    output logic [15:0]                   o_m_axis_tdata
);
    import pgs_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ACCESS = 3'd2;
    localparam logic [2:0] ST_COUNT  = 3'd3;

    logic [2:0]            r_state;
    logic [GS_AW-1:0]      r_clr_addr;
    logic [IND_CNT_W-1:0]  r_ind_cnt;
    logic [CNT_W-1:0]      r_stride_cnt;
    logic [CNT_W-1:0]      r_valid_cnt;

    logic [1:0]            r_kind;
    logic [ERR_W-1:0]      r_err;
    logic [GS_AW-1:0]      r_addr;
    logic [1:0]            r_shift;
    logic [GENO_W-1:0]     r_geno;

    logic                  r_out_valid;
    logic [15:0]           r_out_data;

    logic [1:0]            in_kind;
    logic [ROW_W-1:0]      in_row;
    logic [SNP_W-1:0]      in_snp;
    logic [GENO_W-1:0]     in_geno;
    logic                  accept;
    logic [ERR_W-1:0]      in_err;
    logic [GS_AW-1:0]      in_addr;

    logic                  out_free;
    logic                  finish;
    logic                  clearing;

    t_geno_rd              cnt_rd;
    t_tab_wr               cnt_wr;
    logic                  cnt_busy;

    logic                  gs_we;
    logic [GS_AW-1:0]      gs_waddr;
    logic [7:0]            gs_wdata;
    logic                  gs_re;
    logic [GS_AW-1:0]      gs_raddr;
    logic [7:0]            gs_rdata;
    logic [7:0]            gs_merged;

    logic                  ct_we;
    logic [CT_AW-1:0]      ct_waddr;
    logic [TOTAL_W-1:0]    ct_wdata;
    logic                  ct_re;
    logic [TOTAL_W-1:0]    ct_rdata;

    logic [GENO_W-1:0]     res_geno;
    logic [TOTAL_W-1:0]    res_total;
    logic [ERR_W-1:0]      res_err;

    assign in_kind = i_s_axis_tuser;
    assign in_row  = i_s_axis_tdata[7:0];
    assign in_snp  = i_s_axis_tdata[17:8];
    assign in_geno = i_s_axis_tdata[19:18];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign clearing        = (r_state == ST_CLEAR);

    always_comb begin
        if ({1'b0, in_row} >= r_ind_cnt) begin
            in_err = ERR_IND;
        end else if ({1'b0, in_snp} >= r_valid_cnt) begin
            in_err = ERR_SNP;
        end else begin
            in_err = ERR_OK;
        end
    end

    assign in_addr = geno_addr({1'b0, in_row}, r_stride_cnt, in_snp);

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign finish   = (r_state == ST_ACCESS) && out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ind_cnt    <= IND_CNT_W'(1);
            r_stride_cnt <= '0;
            r_valid_cnt  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IND_CNT:    r_ind_cnt    <= i_cfg_wdata[IND_CNT_W-1:0];
                CFG_STRIDE_CNT: r_stride_cnt <= i_cfg_wdata;
                CFG_VALID_CNT:  r_valid_cnt  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + GS_AW'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= (in_kind == KIND_COUNT) ? ST_COUNT : ST_ACCESS;
                    end
                end
                ST_COUNT: begin
                    if (!cnt_busy) begin
                        r_state <= ST_ACCESS;
                    end
                end
                ST_ACCESS: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // request context held for the access state
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= in_kind;
            r_err   <= ((in_kind == KIND_READ) || (in_kind == KIND_WRITE)) ? in_err : ERR_OK;
            r_addr  <= in_addr;
            r_shift <= in_snp[1:0];
            r_geno  <= in_geno;
        end
    end

    pgs_count u_count (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept && (in_kind == KIND_COUNT)),
        .i_ind_cnt    (r_ind_cnt),
        .i_stride_cnt (r_stride_cnt),
        .i_valid_cnt  (r_valid_cnt),
        .i_geno_rdata (gs_rdata),
        .o_geno_rd    (cnt_rd),
        .o_tab_wr     (cnt_wr),
        .o_busy       (cnt_busy)
    );

    // Replace the addressed 2-bit field of the byte read back.
    always_comb begin
        gs_merged = gs_rdata;
        gs_merged[{r_shift, 1'b0} +: GENO_W] = r_geno;
    end

    assign gs_re    = (accept && ((in_kind == KIND_READ) || (in_kind == KIND_WRITE)))
                      || cnt_rd.en;
    assign gs_raddr = cnt_rd.en ? cnt_rd.addr : in_addr;
    assign gs_we    = clearing
                      || (finish && (r_kind == KIND_WRITE) && (r_err == ERR_OK));
    assign gs_waddr = clearing ? r_clr_addr : r_addr;
    assign gs_wdata = clearing ? 8'h00 : gs_merged;

    pgs_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (8)
    ) u_geno_mem (
        .i_clk   (i_clk),
        .i_we    (gs_we),
        .i_waddr (gs_waddr),
        .i_wdata (gs_wdata),
        .i_re    (gs_re),
        .i_raddr (gs_raddr),
        .o_rdata (gs_rdata)
    );

    // The count table is cleared during the first entries of the clearing pass.
    assign ct_we    = (clearing && (r_clr_addr[GS_AW-1:CT_AW] == '0)) || cnt_wr.en;
    assign ct_waddr = clearing ? r_clr_addr[CT_AW-1:0] : cnt_wr.addr;
    assign ct_wdata = clearing ? '0 : cnt_wr.data;
    assign ct_re    = accept && (in_kind == KIND_READ_CNT);

    pgs_ram #(
        .DEPTH (MAX_SNPS),
        .WIDTH (TOTAL_W)
    ) u_count_mem (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (ct_waddr),
        .i_wdata (ct_wdata),
        .i_re    (ct_re),
        .i_raddr (in_snp[CT_AW-1:0]),
        .o_rdata (ct_rdata)
    );

    always_comb begin
        res_geno  = '0;
        res_total = '0;
        res_err   = r_err;
        case (r_kind)
            KIND_READ: begin
                if (r_err == ERR_OK) begin
                    res_geno = gs_rdata[{r_shift, 1'b0} +: GENO_W];
                end
            end
            KIND_READ_CNT: res_total = ct_rdata;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data <= {2'b00, res_err, res_total, res_geno};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
